// ----- rtl/dtrw_pkg.sv -----
`default_nettype none

package dtrw_pkg;

	localparam int FRAME_WORDS_DEF = 65536;

	localparam int XW     = 11;
	localparam int DIMW   = 10;
	localparam int STRW   = 11;
	localparam int MODEW  = 3;
	localparam int DW     = 32;
	localparam int SAW    = 16;
	localparam int OAW    = 16;
	localparam int ZW     = 16;
	localparam int POSW   = XW + 1;
	localparam int PRODW  = POSW + STRW;
	localparam int PADDRW = PRODW + 1;

	localparam logic [STRW-1:0] STRIDE_MASK = 11'h7F8;

	localparam int QUEUE_DEPTH = 4;
	localparam int OUT_DEPTH   = 4;
	localparam int QCW         = $clog2(QUEUE_DEPTH + 1);
	localparam int OCW         = $clog2(OUT_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_RECT     = 2'd0,
		KIND_PIXEL    = 2'd1,
		KIND_STORE_WR = 2'd2,
		KIND_STORE_RD = 2'd3
	} kind_t;

	typedef enum logic [MODEW-1:0] {
		MODE_NONE  = 3'd0,
		MODE_LT    = 3'd1,
		MODE_EQ    = 3'd2,
		MODE_LE    = 3'd3,
		MODE_GT    = 3'd4,
		MODE_NE    = 3'd5,
		MODE_GE    = 3'd6,
		MODE_PIXEL = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		OP_NONE     = 2'd0,
		OP_PIXEL    = 2'd1,
		OP_STORE_WR = 2'd2,
		OP_STORE_RD = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [XW-1:0]    x_start;
		logic [XW-1:0]    y_start;
		logic [DIMW-1:0]  width;
		logic [DIMW-1:0]  height;
		logic [STRW-1:0]  stride;
		logic [MODEW-1:0] compare_mode;
		logic             fill_enable;
		logic             chain;
		logic [DW-1:0]    data;
		logic [SAW-1:0]   store_address;
	} item_t;

	typedef struct packed {
		logic [OAW-1:0] word_address;
		logic           written;
		logic [DW-1:0]  read_data;
		logic           last;
		logic           error;
	} result_t;

	// err set: job never writes the store
	typedef struct packed {
		op_t               op;
		logic [PADDRW-1:0] addr;
		logic [DW-1:0]     word;
		mode_t             mode;
		logic              last;
		logic              err;
	} job_t;

	function automatic logic z_blocks(mode_t mode, logic [DW-1:0] stored,
			logic [DW-1:0] incoming);
		logic [ZW-1:0] zs;
		logic [ZW-1:0] zi;
		logic          blk;
		zs = stored[ZW-1:0];
		zi = incoming[ZW-1:0];
		case (mode)
			MODE_LT: blk = zs < zi;
			MODE_EQ: blk = zs == zi;
			MODE_LE: blk = zs <= zi;
			MODE_GT: blk = zs > zi;
			MODE_NE: blk = zs != zi;
			MODE_GE: blk = zs >= zi;
			default: blk = 1'b0;
		endcase
		return blk;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/dtrw_if.sv -----
`default_nettype none

interface dtrw_item_if;
	logic                  valid;
	logic                  ready;
	dtrw_pkg::item_t       payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface dtrw_result_if;
	logic                  valid;
	logic                  ready;
	dtrw_pkg::result_t     payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/dtrw_ram.sv -----
`default_nettype none

module dtrw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read-first on a same-address collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/dtrw_queue.sv -----
`default_nettype none

module dtrw_queue #(
	parameter int DEPTH = 4,
	parameter type entry_t = logic,
	localparam int PW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire entry_t        push_data,
	input  wire logic          pop,
	output entry_t             head,
	output logic               nonempty,
	output logic    [CW-1:0]   count
);

	entry_t          mem_q [DEPTH];
	logic   [PW-1:0] wr_ptr_q;
	logic   [PW-1:0] rd_ptr_q;
	logic   [CW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign head     = mem_q[rd_ptr_q];
	assign nonempty = count_q != '0;
	assign count    = count_q;

endmodule

`default_nettype wire

// ----- rtl/dtrw_front.sv -----
`default_nettype none

module dtrw_front #(
	parameter int FRAME_WORDS = dtrw_pkg::FRAME_WORDS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	dtrw_item_if.sink                     items,
	input  wire logic                     hold,
	input  wire logic [dtrw_pkg::QCW-1:0] q_count,
	output dtrw_pkg::job_t                job,
	output logic                          job_push
);

	localparam logic [dtrw_pkg::PADDRW:0] LIMIT = (dtrw_pkg::PADDRW + 1)'(FRAME_WORDS);

	typedef struct packed {
		dtrw_pkg::op_t                 op;
		logic [dtrw_pkg::POSW-1:0]     row_abs;
		logic [dtrw_pkg::POSW-1:0]     col_abs;
		logic [dtrw_pkg::STRW-1:0]     stride;
		logic [dtrw_pkg::DW-1:0]       word;
		dtrw_pkg::mode_t               mode;
		logic                          last;
		logic                          err;
		logic [dtrw_pkg::SAW-1:0]      saddr;
	} stage_t;

	logic [dtrw_pkg::XW-1:0]   rect_x_q;
	logic [dtrw_pkg::XW-1:0]   rect_y_q;
	logic [dtrw_pkg::DIMW-1:0] rect_w_q;
	logic [dtrw_pkg::DIMW-1:0] rect_h_q;
	logic [dtrw_pkg::STRW-1:0] stride_q;
	dtrw_pkg::mode_t           mode_q;
	logic                      fill_q;
	logic [dtrw_pkg::DW-1:0]   fill_word_q;
	logic [dtrw_pkg::DIMW-1:0] col_q;
	logic [dtrw_pkg::DIMW-1:0] row_q;
	logic                      active_q;

	logic                      accept;
	logic [dtrw_pkg::DIMW:0]   col_inc;
	logic [dtrw_pkg::DIMW:0]   row_inc;
	logic                      col_wrap;
	logic                      row_wrap;
	logic [dtrw_pkg::QCW:0]    occupancy;
	stage_t                    stage_d;

	logic                       v_s1;
	stage_t                     item_s1;
	logic                       v_s2;
	stage_t                     item_s2;
	logic [dtrw_pkg::PRODW-1:0] prod_s2;

	logic [dtrw_pkg::PADDRW-1:0] addr;
	logic                        in_range;

	assign occupancy   = (dtrw_pkg::QCW + 1)'(q_count) + (dtrw_pkg::QCW + 1)'(v_s1)
			+ (dtrw_pkg::QCW + 1)'(v_s2);
	assign items.ready = !hold && (occupancy < (dtrw_pkg::QCW + 1)'(dtrw_pkg::QUEUE_DEPTH));
	assign accept      = items.valid && items.ready;

	assign col_inc  = {1'b0, col_q} + 1'b1;
	assign row_inc  = {1'b0, row_q} + 1'b1;
	assign col_wrap = col_inc >= {1'b0, rect_w_q};
	assign row_wrap = row_inc >= {1'b0, rect_h_q};

	always_comb begin
		stage_d.op      = dtrw_pkg::OP_NONE;
		stage_d.row_abs = dtrw_pkg::POSW'(rect_y_q) + dtrw_pkg::POSW'(row_q);
		stage_d.col_abs = dtrw_pkg::POSW'(rect_x_q) + dtrw_pkg::POSW'(col_q);
		stage_d.stride  = stride_q;
		stage_d.word    = fill_q ? fill_word_q : items.payload.data;
		stage_d.mode    = mode_q;
		stage_d.last    = 1'b0;
		stage_d.err     = 1'b0;
		stage_d.saddr   = items.payload.store_address;
		case (dtrw_pkg::kind_t'(items.payload.kind))
			dtrw_pkg::KIND_RECT: begin
				stage_d.op = dtrw_pkg::OP_NONE;
			end
			dtrw_pkg::KIND_PIXEL: begin
				if (active_q) begin
					stage_d.op   = dtrw_pkg::OP_PIXEL;
					stage_d.last = col_wrap && row_wrap;
				end else begin
					stage_d.err = 1'b1;
				end
			end
			dtrw_pkg::KIND_STORE_WR: begin
				stage_d.op   = dtrw_pkg::OP_STORE_WR;
				stage_d.word = items.payload.data;
			end
			default: begin
				stage_d.op = dtrw_pkg::OP_STORE_RD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_x_q    <= '0;
			rect_y_q    <= '0;
			rect_w_q    <= '0;
			rect_h_q    <= '0;
			stride_q    <= '0;
			mode_q      <= dtrw_pkg::MODE_PIXEL;
			fill_q      <= 1'b0;
			fill_word_q <= '0;
			col_q       <= '0;
			row_q       <= '0;
			active_q    <= 1'b0;
		end else if (accept) begin
			if (items.payload.kind == dtrw_pkg::KIND_RECT && !items.payload.chain) begin
				rect_x_q    <= items.payload.x_start;
				rect_y_q    <= items.payload.y_start;
				rect_w_q    <= items.payload.width;
				rect_h_q    <= items.payload.height;
				stride_q    <= items.payload.stride & dtrw_pkg::STRIDE_MASK;
				mode_q      <= dtrw_pkg::mode_t'(items.payload.compare_mode);
				fill_q      <= items.payload.fill_enable;
				fill_word_q <= items.payload.data;
				col_q       <= '0;
				row_q       <= '0;
				active_q    <= (items.payload.width != '0) && (items.payload.height != '0);
			end else if (items.payload.kind == dtrw_pkg::KIND_PIXEL && active_q) begin
				if (col_wrap) begin
					col_q <= '0;
					if (row_wrap) begin
						row_q    <= '0;
						active_q <= 1'b0;
					end else begin
						row_q <= row_inc[dtrw_pkg::DIMW-1:0];
					end
				end else begin
					col_q <= col_inc[dtrw_pkg::DIMW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= stage_d;
		item_s2 <= item_s1;
		prod_s2 <= dtrw_pkg::PRODW'(item_s1.row_abs) * dtrw_pkg::PRODW'(item_s1.stride);
	end

	always_comb begin
		if (item_s2.op == dtrw_pkg::OP_PIXEL) begin
			addr = dtrw_pkg::PADDRW'(prod_s2) + dtrw_pkg::PADDRW'(item_s2.col_abs);
		end else begin
			addr = dtrw_pkg::PADDRW'(item_s2.saddr);
		end
		in_range = {1'b0, addr} < LIMIT;
		job.op   = item_s2.op;
		job.addr = addr;
		job.word = item_s2.word;
		job.mode = item_s2.mode;
		job.last = item_s2.last;
		job.err  = item_s2.err || (item_s2.op != dtrw_pkg::OP_NONE && !in_range);
	end

	assign job_push = v_s2;

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> q_count < dtrw_pkg::QCW'(dtrw_pkg::QUEUE_DEPTH))
		else $error("job queue overrun");

	a_last_ends_rect: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && items.payload.kind == dtrw_pkg::KIND_PIXEL && active_q
			&& col_wrap && row_wrap) |=> !active_q)
		else $error("rectangle still active after final pixel");

endmodule

`default_nettype wire

// ----- rtl/dtrw_back.sv -----
`default_nettype none

module dtrw_back #(
	parameter int FRAME_WORDS = dtrw_pkg::FRAME_WORDS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire dtrw_pkg::job_t           head,
	input  wire logic                     q_valid,
	output logic                          q_pop,
	output logic                          clearing,
	output dtrw_pkg::result_t             res,
	output logic                          res_push,
	input  wire logic [dtrw_pkg::OCW-1:0] out_count
);

	localparam int AW = $clog2(FRAME_WORDS);

	logic                    clearing_q;
	logic [AW-1:0]           clr_addr_q;

	logic                    v_b2;
	dtrw_pkg::job_t          job_b2;

	logic                    fwd_v_q;
	logic [AW-1:0]           fwd_addr_q;
	logic [dtrw_pkg::DW-1:0] fwd_data_q;

	logic [dtrw_pkg::DW-1:0] ram_rdata;
	logic [dtrw_pkg::DW-1:0] stored;
	logic                    wr;
	logic [dtrw_pkg::DW-1:0] rd;
	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [dtrw_pkg::DW-1:0] ram_wdata;
	logic [dtrw_pkg::OCW:0]  out_occ;

	assign out_occ  = (dtrw_pkg::OCW + 1)'(out_count) + (dtrw_pkg::OCW + 1)'(v_b2);
	assign q_pop    = q_valid && !clearing_q
			&& (out_occ < (dtrw_pkg::OCW + 1)'(dtrw_pkg::OUT_DEPTH));
	assign clearing = clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			v_b2       <= 1'b0;
			fwd_v_q    <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(FRAME_WORDS - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			v_b2    <= q_pop;
			fwd_v_q <= v_b2 && wr;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_b2 <= head;
		end
		fwd_addr_q <= job_b2.addr[AW-1:0];
		fwd_data_q <= job_b2.word;
	end

	dtrw_ram #(
		.WIDTH (dtrw_pkg::DW),
		.DEPTH (FRAME_WORDS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (q_pop),
		.raddr (head.addr[AW-1:0]),
		.rdata (ram_rdata)
	);

	// write in the previous cycle is not yet visible to this read
	assign stored = (fwd_v_q && fwd_addr_q == job_b2.addr[AW-1:0]) ? fwd_data_q : ram_rdata;

	always_comb begin
		wr = 1'b0;
		rd = '0;
		case (job_b2.op)
			dtrw_pkg::OP_PIXEL: begin
				wr = !job_b2.err && !dtrw_pkg::z_blocks(job_b2.mode, stored, job_b2.word);
			end
			dtrw_pkg::OP_STORE_WR: begin
				wr = !job_b2.err;
			end
			dtrw_pkg::OP_STORE_RD: begin
				rd = job_b2.err ? '0 : stored;
			end
			default: begin
				wr = 1'b0;
			end
		endcase
	end

	assign ram_we    = clearing_q || (v_b2 && wr);
	assign ram_waddr = clearing_q ? clr_addr_q : job_b2.addr[AW-1:0];
	assign ram_wdata = clearing_q ? '0 : job_b2.word;

	always_comb begin
		res.word_address = (job_b2.op == dtrw_pkg::OP_NONE) ? '0
				: job_b2.addr[dtrw_pkg::OAW-1:0];
		res.written      = wr;
		res.read_data    = rd;
		res.last         = job_b2.last;
		res.error        = job_b2.err;
	end

	assign res_push = v_b2;

	a_no_pop_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !q_pop)
		else $error("job taken during clearing pass");

	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> out_count < dtrw_pkg::OCW'(dtrw_pkg::OUT_DEPTH))
		else $error("result queue overrun");

	a_err_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(v_b2 && job_b2.err) |-> !ram_we)
		else $error("store written for a faulted job");

	a_clear_no_job: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !v_b2)
		else $error("job in flight during clearing pass");

endmodule

`default_nettype wire

// ----- rtl/depth_tested_rect_pixel_writer_top.sv -----
// Path: front s1, s2, job queue, back b2, out queue; a stalled sink holds results back.
// Throughput: one item per cycle while the queues have room; a depth read-modify-write
// to the same word in consecutive cycles is forwarded, so store dependencies never stall.
// Pixel address is formed in a 2-stage multiply-add front end, store access in the back end.
// Reset: asynchronous; the frame store is then cleared one word a cycle, from word 0
// to FRAME_WORDS-1, during which no item beat is taken.
`default_nettype none

module depth_tested_rect_pixel_writer_top #(
	parameter int FRAME_WORDS = dtrw_pkg::FRAME_WORDS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dtrw_item_if.sink  items,
	dtrw_result_if.source results
);

	dtrw_pkg::job_t           job;
	logic                     job_push;
	dtrw_pkg::job_t           job_head;
	logic                     job_valid;
	logic                     job_pop;
	logic [dtrw_pkg::QCW-1:0] job_count;
	logic                     clearing;

	dtrw_pkg::result_t        res;
	logic                     res_push;
	logic [dtrw_pkg::OCW-1:0] out_count;
	logic                     out_pop;

	dtrw_front #(
		.FRAME_WORDS (FRAME_WORDS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items),
		.hold     (clearing),
		.q_count  (job_count),
		.job      (job),
		.job_push (job_push)
	);

	dtrw_queue #(
		.DEPTH   (dtrw_pkg::QUEUE_DEPTH),
		.entry_t (dtrw_pkg::job_t)
	) u_job_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job),
		.pop       (job_pop),
		.head      (job_head),
		.nonempty  (job_valid),
		.count     (job_count)
	);

	dtrw_back #(
		.FRAME_WORDS (FRAME_WORDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (job_head),
		.q_valid   (job_valid),
		.q_pop     (job_pop),
		.clearing  (clearing),
		.res       (res),
		.res_push  (res_push),
		.out_count (out_count)
	);

	dtrw_queue #(
		.DEPTH   (dtrw_pkg::OUT_DEPTH),
		.entry_t (dtrw_pkg::result_t)
	) u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res),
		.pop       (out_pop),
		.head      (results.payload),
		.nonempty  (results.valid),
		.count     (out_count)
	);

	assign out_pop = results.valid && results.ready;

endmodule

`default_nettype wire

// ----- test/depth_tested_rect_pixel_writer_top_tb.sv -----
`timescale 1ns / 1ps

module depth_tested_rect_pixel_writer_top_tb;
	import dtrw_pkg::*;

	localparam int FW           = FRAME_WORDS_DEF;
	localparam int FAW          = $clog2(FW);
	localparam int STALL_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 16;
	localparam int ITEM_TARGET  = 1200;

	logic clk;
	logic arst_n;

	dtrw_item_if   items_if ();
	dtrw_result_if results_if ();

	depth_tested_rect_pixel_writer_top #(.FRAME_WORDS(FW)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_if),
		.results(results_if)
	);

	// shadow of the frame store and the rectangle walker
	logic [DW-1:0]   frame_mem [0:FW-1];
	logic [XW-1:0]   cur_x;
	logic [XW-1:0]   cur_y;
	logic [DIMW-1:0] cur_w;
	logic [DIMW-1:0] cur_h;
	logic [STRW-1:0] cur_stride;
	mode_t           cur_mode;
	logic            cur_fill;
	logic [DW-1:0]   cur_fill_word;
	logic [DIMW-1:0] col_pos;
	logic [DIMW-1:0] row_pos;
	logic            rect_busy;

	result_t     expected_q [$];
	result_t     want_r;
	int          errors = 0;
	int          items_sent = 0;
	int          idle_count = 0;
	int unsigned stall_left = 0;
	bit          gaps_on = 1'b1;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic bit depth_rejects(mode_t m, logic [DW-1:0] old_word,
			logic [DW-1:0] new_word);
		logic [ZW-1:0] zo;
		logic [ZW-1:0] zn;
		zo = old_word[ZW-1:0];
		zn = new_word[ZW-1:0];
		case (m)
			MODE_LT: return zo < zn;
			MODE_EQ: return zo == zn;
			MODE_LE: return zo <= zn;
			MODE_GT: return zo > zn;
			MODE_NE: return zo != zn;
			MODE_GE: return zo >= zn;
			default: return 1'b0;
		endcase
	endfunction

	function automatic result_t apply_item(item_t it);
		result_t     r;
		logic [31:0] addr;
		logic [31:0] word;
		r = '0;
		case (it.kind)
			KIND_RECT: begin
				if (!it.chain) begin
					cur_x         = it.x_start;
					cur_y         = it.y_start;
					cur_w         = it.width;
					cur_h         = it.height;
					cur_stride    = it.stride & STRIDE_MASK;
					cur_mode      = mode_t'(it.compare_mode);
					cur_fill      = it.fill_enable;
					cur_fill_word = it.data;
					col_pos       = '0;
					row_pos       = '0;
					rect_busy     = (it.width != 0) && (it.height != 0);
				end
			end
			KIND_PIXEL: begin
				if (!rect_busy) begin
					r.error = 1'b1;
				end else begin
					addr = (32'(cur_y) + 32'(row_pos)) * 32'(cur_stride)
						+ 32'(cur_x) + 32'(col_pos);
					word = cur_fill ? cur_fill_word : it.data;
					r.word_address = addr[OAW-1:0];
					if (addr < FW) begin
						if (!depth_rejects(cur_mode, frame_mem[addr[FAW-1:0]], word)) begin
							frame_mem[addr[FAW-1:0]] = word;
							r.written = 1'b1;
						end
					end else begin
						r.error = 1'b1;
					end
					if (32'(col_pos) + 1 >= 32'(cur_w)) begin
						col_pos = '0;
						if (32'(row_pos) + 1 >= 32'(cur_h)) begin
							row_pos   = '0;
							r.last    = 1'b1;
							rect_busy = 1'b0;
						end else begin
							row_pos = row_pos + 1'b1;
						end
					end else begin
						col_pos = col_pos + 1'b1;
					end
				end
			end
			default: begin
				r.word_address = it.store_address;
				if (32'(it.store_address) < FW) begin
					if (it.kind == KIND_STORE_WR) begin
						frame_mem[it.store_address] = it.data;
						r.written = 1'b1;
					end else begin
						r.read_data = frame_mem[it.store_address];
					end
				end else begin
					r.error = 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	task automatic send_item(input item_t it);
		int unsigned gap;
		gap = gap_len();
		if (gap != 0) begin
			items_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items_if.valid   <= 1'b1;
		items_if.payload <= it;
		do
			@(posedge clk);
		while (!items_if.ready);
		expected_q.push_back(apply_item(it));
		items_sent++;
	endtask

	function automatic item_t noise_item();
		item_t it;
		it.kind          = 2'($urandom_range(0, 3));
		it.x_start       = XW'($urandom);
		it.y_start       = XW'($urandom);
		it.width         = DIMW'($urandom);
		it.height        = DIMW'($urandom);
		it.stride        = STRW'($urandom);
		it.compare_mode  = MODEW'($urandom);
		it.fill_enable   = 1'($urandom);
		it.chain         = 1'($urandom);
		it.data          = $urandom;
		it.store_address = SAW'($urandom);
		return it;
	endfunction

	function automatic item_t rect_cmd(int unsigned x, int unsigned y, int unsigned w,
			int unsigned h, int unsigned stride, mode_t m, bit fill, logic [DW-1:0] fword);
		item_t it;
		it              = noise_item();
		it.kind         = KIND_RECT;
		it.chain        = 1'b0;
		it.x_start      = XW'(x);
		it.y_start      = XW'(y);
		it.width        = DIMW'(w);
		it.height       = DIMW'(h);
		it.stride       = STRW'(stride);
		it.compare_mode = m;
		it.fill_enable  = fill;
		it.data         = fword;
		return it;
	endfunction

	function automatic item_t pixel_item(logic [DW-1:0] d);
		item_t it;
		it      = noise_item();
		it.kind = KIND_PIXEL;
		it.data = d;
		return it;
	endfunction

	function automatic item_t store_item(kind_t k, logic [SAW-1:0] a, logic [DW-1:0] d);
		item_t it;
		it               = noise_item();
		it.kind          = k;
		it.store_address = a;
		it.data          = d;
		return it;
	endfunction

	// Z mostly from a tiny set so every relation both holds and fails
	function automatic logic [DW-1:0] z_word();
		logic [DW-1:0] w;
		int unsigned   r;
		w = $urandom;
		r = $urandom_range(0, 9);
		if (r < 7)
			w[ZW-1:0] = ZW'($urandom_range(0, 3));
		else if (r == 7)
			w[ZW-1:0] = '1;
		else if (r == 8)
			w[ZW-1:0] = '0;
		return w;
	endfunction

	function automatic int unsigned pick_stride();
		int unsigned s;
		case ($urandom_range(0, 5))
			0: s = 0;
			1: s = 8;
			2: s = 16;
			3: s = 32;
			4: s = 64;
			default: s = 2040;
		endcase
		return s | $urandom_range(0, 7);
	endfunction

	task automatic test_unarmed_pixel_and_store();
		send_item(pixel_item(32'hFFFF_FFFF));
		send_item(store_item(KIND_STORE_RD, 16'h0000, $urandom));
		send_item(store_item(KIND_STORE_WR, 16'hFFFF, 32'hFFFF_FFFF));
		send_item(store_item(KIND_STORE_RD, 16'hFFFF, $urandom));
	endtask

	task automatic test_empty_and_chained_commands();
		item_t it;
		send_item(rect_cmd(5, 1, 0, 7, 16, MODE_NONE, 1'b0, $urandom));
		send_item(pixel_item(z_word()));
		send_item(rect_cmd(5, 1, 3, 0, 16, MODE_NONE, 1'b0, $urandom));
		send_item(rect_cmd(4, 2, 2, 2, 16, MODE_NONE, 1'b0, $urandom));
		send_item(pixel_item(z_word()));
		it       = noise_item();
		it.kind  = KIND_RECT;
		it.chain = 1'b1;
		send_item(it);
		repeat (3) send_item(pixel_item(z_word()));
		send_item(pixel_item(z_word()));
	endtask

	task automatic test_fill_and_out_of_range();
		send_item(store_item(KIND_STORE_WR, 16'd40, 32'h1234_0002));
		send_item(rect_cmd(40, 0, 2, 1, 0, MODE_LT, 1'b1, 32'hABCD_0002));
		repeat (2) send_item(pixel_item($urandom));
		send_item(store_item(KIND_STORE_RD, 16'd40, $urandom));
		send_item(rect_cmd(2047, 2047, 1023, 1023, 11'h7FF, MODE_PIXEL, 1'b0, $urandom));
		repeat (2) send_item(pixel_item($urandom));
		send_item(rect_cmd(0, 0, 1023, 1023, 0, MODE_GE, 1'b0, $urandom));
		send_item(pixel_item(32'h0000_FFFF));
		send_item(pixel_item(32'hFFFF_0000));
		send_item(rect_cmd(0, 0, 1023, 0, 0, MODE_NONE, 1'b0, $urandom));
	endtask

	task automatic test_random_traffic();
		int unsigned w;
		int unsigned h;
		int unsigned n;
		int unsigned k;
		int unsigned s;
		int unsigned y;
		item_t       it;
		while (items_sent < ITEM_TARGET) begin
			gaps_on = ($urandom_range(0, 4) != 0);
			if ($urandom_range(0, 9) < 7) begin
				repeat ($urandom_range(0, 3))
					send_item(store_item(KIND_STORE_WR, SAW'($urandom_range(0, 1023)),
						z_word()));
				w = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
				h = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
				s = pick_stride();
				y = ($urandom_range(0, 4) == 0) ? $urandom_range(24, 40) : $urandom_range(0, 15);
				send_item(rect_cmd($urandom_range(0, 31), y, w, h, s,
					mode_t'($urandom_range(0, 7)), ($urandom_range(0, 3) == 0), z_word()));
				n = w * h;
				if ($urandom_range(0, 9) == 0)
					n = $urandom_range(0, n);
				for (k = 0; k < n && items_sent < ITEM_TARGET; k++) begin
					if ($urandom_range(0, 19) == 0) begin
						it = noise_item();
						case ($urandom_range(0, 2))
							0: begin
								it.kind  = KIND_RECT;
								it.chain = 1'b1;
							end
							1: begin
								it.kind          = KIND_STORE_WR;
								it.store_address = SAW'($urandom_range(0, 1023));
								it.data          = z_word();
							end
							default: begin
								it.kind          = KIND_STORE_RD;
								it.store_address = SAW'($urandom_range(0, 1023));
							end
						endcase
						send_item(it);
					end
					send_item(pixel_item(z_word()));
				end
				repeat ($urandom_range(0, 2))
					send_item(store_item(KIND_STORE_RD, SAW'($urandom_range(0, 1023)),
						$urandom));
			end else begin
				repeat ($urandom_range(1, 8)) send_item(noise_item());
			end
		end
		gaps_on = 1'b1;
	endtask

	task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, what, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			results_if.ready <= 1'b0;
			stall_left       <= stall_left - 1;
		end else begin
			results_if.ready <= 1'b1;
			stall_left       <= gap_len();
		end
	end

	always @(posedge clk) begin
		if (results_if.valid && results_if.ready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: result beat with nothing expected, got %p", $time,
					results_if.payload);
				errors++;
			end else begin
				want_r = expected_q.pop_front();
				check_field("word_address", 32'(want_r.word_address),
					32'(results_if.payload.word_address));
				check_field("written", 32'(want_r.written), 32'(results_if.payload.written));
				check_field("read_data", want_r.read_data, results_if.payload.read_data);
				check_field("last", 32'(want_r.last), 32'(results_if.payload.last));
				check_field("error", 32'(want_r.error), 32'(results_if.payload.error));
			end
		end
	end

	always @(posedge clk) begin
		if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready)) begin
			idle_count <= 0;
		end else if (idle_count >= STALL_LIMIT) begin
			$display("%0t: no beat for %0d cycles, %0d results outstanding", $time,
				idle_count, expected_q.size());
			$display("depth_tested_rect_pixel_writer_top_tb: errors");
			$finish;
		end else begin
			idle_count <= idle_count + 1;
		end
	end

	initial begin
		int i;
		arst_n             = 1'b0;
		items_if.valid     = 1'b0;
		items_if.payload   = '0;
		results_if.ready   = 1'b0;
		for (i = 0; i < FW; i++)
			frame_mem[FAW'(i)] = '0;
		cur_x         = '0;
		cur_y         = '0;
		cur_w         = '0;
		cur_h         = '0;
		cur_stride    = '0;
		cur_mode      = MODE_PIXEL;
		cur_fill      = 1'b0;
		cur_fill_word = '0;
		col_pos       = '0;
		row_pos       = '0;
		rect_busy     = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_unarmed_pixel_and_store();
		test_empty_and_chained_commands();
		test_fill_and_out_of_range();
		test_random_traffic();
		items_if.valid <= 1'b0;

		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("depth_tested_rect_pixel_writer_top_tb: clean");
		else
			$display("depth_tested_rect_pixel_writer_top_tb: errors");
		$finish;
	end

endmodule
